// ----- rtl/core/upd_pkg.sv -----
// Shared types, constants and helper functions of the URI percent decoder.
package upd_pkg;

  // Characters with a meaning of their own in the encoded text.
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Output buffer size of the string consumer; the limit can never exceed it minus one.
  localparam int unsigned BUFFER_BYTES = 4096;
  localparam int unsigned LIMIT_W      = 12;
  localparam int unsigned LIMIT_MAX    = (1 << LIMIT_W) - 1;
  localparam logic [LIMIT_W-1:0] LIMIT_CAP =
      LIMIT_W'((BUFFER_BYTES - 1 > LIMIT_MAX) ? LIMIT_MAX : BUFFER_BYTES - 1);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(LIMIT_MAX);

  // Depth of the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Most operations that one input byte can cause.
  localparam int unsigned MAX_OPS = 3;

  // Escape parser state.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PCT,
    ST_DIGIT
  } esc_state_t;

  // One operation for the back end: a decoded byte or an end of string.
  typedef struct packed {
    logic       is_end;
    logic [7:0] data;
  } op_t;

  // All operations caused by one input byte, oldest in slot 0.
  typedef struct packed {
    logic [1:0]          count;
    op_t [MAX_OPS-1:0]   ops;
  } bundle_t;

  // Queue handshake seen by the back end.
  typedef struct packed {
    logic empty;
    logic pop;
  } q_ctrl_t;

  // True for 0-9, a-f and A-F.
  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  // Value of one hex digit; only called on a valid digit.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

endpackage

// ----- rtl/core/upd_front.sv -----
// Front end: accepts raw bytes, tracks escapes and turns each byte into operations.
module upd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       in_byte,
  output upd_pkg::bundle_t bundle,
  output logic             bundle_valid
);
  import upd_pkg::*;

  esc_state_t state, state_next;
  logic [7:0] digit, digit_next;

  // Operations flushed from an ended escape (decoded or failed), then the one for the fresh byte.
  op_t        pre0, pre1, fresh;
  logic [1:0] pre_n;
  logic       fresh_v;
  logic       handled;

  // State register and the held first digit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (accept) begin
      state <= state_next;
    end
    if (accept) begin
      digit <= digit_next;
    end
  end

  // Escape parsing and operation building.
  always_comb begin
    state_next = state;
    digit_next = digit;
    pre0       = '{is_end: 1'b0, data: CH_PCT};
    pre1       = '{is_end: 1'b0, data: digit};
    pre_n      = 2'd0;
    handled    = 1'b0;
    fresh      = '{is_end: 1'b0, data: in_byte};
    fresh_v    = 1'b0;

    unique case (state)
      ST_PCT: begin
        if (is_hex(in_byte)) begin
          digit_next = in_byte;
          state_next = ST_DIGIT;
          handled    = 1'b1;
        end else begin
          pre_n      = 2'd1;
          state_next = ST_IDLE;
        end
      end
      ST_DIGIT: begin
        if (is_hex(in_byte)) begin
          pre0       = '{is_end: 1'b0, data: {hex_value(digit), hex_value(in_byte)}};
          pre_n      = 2'd1;
          state_next = ST_IDLE;
          handled    = 1'b1;
        end else begin
          pre_n      = 2'd2;
          state_next = ST_IDLE;
        end
      end
      default: begin
      end
    endcase

    // A byte not absorbed by the escape is treated as a fresh byte.
    if (!handled) begin
      priority if (in_byte == CH_NUL) begin
        fresh      = '{is_end: 1'b1, data: CH_NUL};
        fresh_v    = 1'b1;
        state_next = ST_IDLE;
      end else if (in_byte == CH_PLUS) begin
        fresh   = '{is_end: 1'b0, data: CH_SPACE};
        fresh_v = 1'b1;
      end else if (in_byte == CH_PCT) begin
        state_next = ST_PCT;
      end else begin
        fresh_v = 1'b1;
      end
    end

    // Pack the flushed bytes first, the fresh operation after them.
    bundle.ops = '0;
    unique case (pre_n)
      2'd1: begin
        bundle.ops[0] = pre0;
        bundle.ops[1] = fresh;
      end
      2'd2: begin
        bundle.ops[0] = pre0;
        bundle.ops[1] = pre1;
        bundle.ops[2] = fresh;
      end
      default: begin
        bundle.ops[0] = fresh;
      end
    endcase
    bundle.count = pre_n + {1'b0, fresh_v};
    bundle_valid = accept && (bundle.count != 2'd0);
  end

endmodule

// ----- rtl/core/upd_queue.sv -----
// Short queue of operation bundles between the front and the back.
module upd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  upd_pkg::bundle_t wr_bundle,
  output logic             full,
  input  upd_pkg::q_ctrl_t ctrl_in,
  output logic             empty,
  output upd_pkg::bundle_t head
);
  import upd_pkg::*;

  bundle_t           mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QCNT_W-1:0] count;
  logic              rd;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rd    = ctrl_in.pop && !empty;
  assign head  = mem[rptr];

  // Storage, written at the tail.
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wr_bundle;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + QPTR_W'(1);
      end
      if (rd) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(wr) - QCNT_W'(rd);
    end
  end

endmodule

// ----- rtl/core/upd_back.sv -----
// Back end: limits output one operation per cycle unless stalled; holds a result.
module upd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [upd_pkg::LIMIT_W-1:0] cfg_wdata,
  input  logic                        q_empty,
  input  upd_pkg::bundle_t            head,
  output upd_pkg::q_ctrl_t            q_ctrl,
  output logic                        empty,
  input  logic                        pop,
  output logic [7:0]                  out_byte,
  output logic                        is_end,
  output logic                        truncated
);
  import upd_pkg::*;

  logic [LIMIT_W-1:0] limit, eff_limit, emitted;
  logic               dropped;
  logic [1:0]         idx;
  logic               out_valid;
  op_t                op;
  logic               last, room, slot_free, advance, load;

  // Current operation of the head bundle.
  always_comb begin
    unique case (idx)
      2'd1:    op = head.ops[1];
      2'd2:    op = head.ops[2];
      default: op = head.ops[0];
    endcase
  end

  // Decide whether the operation retires this cycle and whether it makes a result.
  assign eff_limit = (limit < LIMIT_CAP) ? limit : LIMIT_CAP;
  assign room      = emitted < eff_limit;
  assign slot_free = !out_valid || pop;
  assign last      = (idx == head.count - 2'd1);
  assign advance   = !q_empty && (slot_free || (!op.is_end && !room));
  assign load      = advance && (op.is_end || room);
  assign q_ctrl    = '{empty: q_empty, pop: advance && last};
  assign empty     = !out_valid;

  // Limit register, bundle index and per-string counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit   <= LIMIT_RESET;
      idx     <= 2'd0;
      emitted <= '0;
      dropped <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
      if (advance) begin
        idx <= last ? 2'd0 : idx + 2'd1;
        if (op.is_end) begin
          emitted <= '0;
          dropped <= 1'b0;
        end else if (room) begin
          emitted <= emitted + LIMIT_W'(1);
        end else begin
          dropped <= 1'b1;
        end
      end
    end
  end

  // Output register: one waiting result.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      out_byte  <= op.data;
      is_end    <= op.is_end;
      truncated <= op.is_end && dropped;
    end
  end

endmodule

// ----- rtl/core/uri_percent_decoder_core.sv -----
// Top level of the streaming URI percent decoder.
//
// Takes one byte of a query-string component per cycle and decodes '+' to a
// space and '%' with two hex digits to the byte they encode; a broken escape is
// passed through literally. A zero byte ends the string and yields an end result
// that reports whether the output limit dropped any bytes. The front accepts a
// new byte every cycle while the four-entry queue has room, and writes the
// operations of that byte into the queue at the accepting edge. The back end
// retires one queued operation per cycle, though one that makes a result waits
// while an earlier result is still unpopped; a byte causes zero to three
// operations, dropped ones retiring as well, and held escape bytes cause none.
// A result passes through the queue and the output register on its way out.
// The limit register may be rewritten only while the block is idle.
module uri_percent_decoder_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  in_byte,
  output logic                        empty,
  input  logic                        pop,
  output logic [7:0]                  out_byte,
  output logic                        is_end,
  output logic                        truncated,
  input  logic                        cfg_we,
  input  logic [upd_pkg::LIMIT_W-1:0] cfg_wdata
);
  import upd_pkg::*;

  logic    accept;
  bundle_t fb, head;
  logic    fb_valid, q_empty;
  q_ctrl_t q_ctrl;

  assign accept = push && !full;

  // Byte classification and escape tracking.
  upd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_byte      (in_byte),
    .bundle       (fb),
    .bundle_valid (fb_valid)
  );

  // Queue between the two halves.
  upd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr        (fb_valid),
    .wr_bundle (fb),
    .full      (full),
    .ctrl_in   (q_ctrl),
    .empty     (q_empty),
    .head      (head)
  );

  // Output limit and result register.
  upd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_empty   (q_empty),
    .head      (head),
    .q_ctrl    (q_ctrl),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .is_end    (is_end),
    .truncated (truncated)
  );

endmodule

// ----- rtl/core/upd_checker.sv -----
// Port-level checks on the decoder, bound to its top level.
module upd_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       is_end,
  input logic       truncated
);

  // Reset leaves no result waiting and room for input.
  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("result or full flag set after reset");

  // An end result always carries a zero byte.
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && is_end) |-> (out_byte == 8'h00))
    else $error("end result with nonzero byte");

  // Only an end result may report truncation.
  a_trunc_only_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && !is_end) |-> !truncated)
    else $error("truncation flag on a data result");

  // A waiting result holds until it is taken.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(is_end) &&
                          $stable(truncated)))
    else $error("waiting result changed before pop");

endmodule

bind uri_percent_decoder_core upd_checker u_upd_checker (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .out_byte  (out_byte),
  .is_end    (is_end),
  .truncated (truncated)
);

// ----- tb/sv/tb_uri_percent_decoder_core.sv -----
// Self-checking testbench for the streaming URI percent decoder core.
module tb_uri_percent_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import upd_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned RANDOM_ITEMS   = 280;
  localparam int unsigned PHASES         = 7;

  // One decoded result as the back end presents it.
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       trunc;
  } decoded_t;

  // Tracks the decoder state and the decoded bytes still owed by the block.
  class decode_scoreboard;
    decoded_t          owed_q[$];
    logic [LIMIT_W-1:0] limit;
    int unsigned       held;
    logic [7:0]        held_digit;
    int unsigned       emitted;
    logic              dropped;
    int unsigned       fails;

    function new();
      limit      = LIMIT_RESET;
      held       = 0;
      held_digit = 8'h00;
      emitted    = 0;
      dropped    = 1'b0;
      fails      = 0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] v);
      limit = v;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Returns the digit value, or -1 when the byte is not a hex digit.
    function int nibble(logic [7:0] c);
      logic [7:0] lc;
      lc = c | 8'h20;
      if (c >= 8'h30 && c <= 8'h39) return int'(c[3:0]);
      if (lc >= 8'h61 && lc <= 8'h66) return int'(lc - 8'h57);
      return -1;
    endfunction

    // A decoded byte counts against the limit; beyond it the byte is lost.
    function void emit(logic [7:0] data);
      decoded_t r;
      int unsigned cap;
      cap = (int'(limit) < BUFFER_BYTES - 1) ? int'(limit) : BUFFER_BYTES - 1;
      if (emitted < cap) begin
        r.data  = data;
        r.last  = 1'b0;
        r.trunc = 1'b0;
        owed_q.push_back(r);
        emitted = emitted + 1;
      end else begin
        dropped = 1'b1;
      end
    endfunction

    // Works out the results of one accepted input request.
    function void note_request(logic [7:0] b);
      decoded_t r;
      int d;
      d = nibble(b);
      if (held == 1) begin
        if (d >= 0) begin
          held_digit = b;
          held = 2;
          return;
        end
        emit(CH_PCT);
        held = 0;
      end else if (held == 2) begin
        if (d >= 0) begin
          emit(8'(nibble(held_digit) * 16 + d));
          held = 0;
          return;
        end
        emit(CH_PCT);
        emit(held_digit);
        held = 0;
      end

      if (b == CH_NUL) begin
        r.data  = 8'h00;
        r.last  = 1'b1;
        r.trunc = dropped;
        owed_q.push_back(r);
        held    = 0;
        emitted = 0;
        dropped = 1'b0;
      end else if (b == CH_PLUS) begin
        emit(CH_SPACE);
      end else if (b == CH_PCT) begin
        held = 1;
      end else begin
        emit(b);
      end
    endfunction

    // Compares one accepted result with the oldest one owed.
    function void check_result(logic [7:0] data, logic last, logic trunc);
      decoded_t e;
      if (owed_q.size() == 0) begin
        $error("unexpected result: out_byte %0h is_end %0b truncated %0b", data, last, trunc);
        fails++;
        return;
      end
      e = owed_q.pop_front();
      if (data !== e.data) begin
        $error("out_byte mismatch: expected %0h, actual %0h", e.data, data);
        fails++;
      end
      if (last !== e.last) begin
        $error("is_end mismatch: expected %0b, actual %0b", e.last, last);
        fails++;
      end
      if (trunc !== e.trunc) begin
        $error("truncated mismatch: expected %0b, actual %0b", e.trunc, trunc);
        fails++;
      end
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               push      = 1'b0;
  logic               full;
  logic [7:0]         in_byte   = 8'h00;
  logic               empty;
  logic               pop       = 1'b0;
  logic [7:0]         out_byte;
  logic               is_end;
  logic               truncated;
  logic               cfg_we    = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;

  decode_scoreboard sb;
  bit               calm         = 1'b0;
  int unsigned      sent         = 0;
  int unsigned      stall_left   = 0;
  int unsigned      quiet_cycles = 0;

  uri_percent_decoder_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_byte   (in_byte),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .is_end    (is_end),
    .truncated (truncated),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Result side: pop with random stall bursts, none once the run is calm.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 7) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Outputs are stable at the falling edge, so each accepted result is checked here.
  always @(negedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        sb.check_result(out_byte, is_end, truncated);
      end
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_uri_percent_decoder_core NOT OK");
        $finish;
      end
    end
  end

  // Sends one request; called and returning at a rising edge.
  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_byte <= b;
    @(negedge clk);
    while (full) begin
      @(negedge clk);
    end
    sb.note_request(b);
    sent++;
    @(posedge clk);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i]);
    end
  endtask

  // Stops sending, waits for every owed result and lets dropped operations still queued retire.
  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Rewrites the limit; only called once the block has drained.
  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_limit(v);
  endtask

  function automatic logic [7:0] hex_char();
    logic [3:0] v;
    v = 4'($urandom);
    if (v < 10) return 8'h30 + v;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 8'd10;
  endfunction

  // One string of mostly well-formed pieces, with broken escapes and raw bytes mixed in.
  task automatic send_random_string();
    int unsigned pieces;
    int unsigned kind;
    pieces = $urandom_range(0, 12);
    repeat (pieces) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        push_byte(8'($urandom_range(8'h21, 8'h7E)));
      end else if (kind < 45) begin
        push_byte(CH_PLUS);
      end else if (kind < 70) begin
        push_byte(CH_PCT);
        push_byte(hex_char());
        push_byte(hex_char());
      end else if (kind < 80) begin
        push_byte(CH_PCT);
        push_byte(hex_char());
      end else if (kind < 88) begin
        push_byte(CH_PCT);
      end else begin
        push_byte(8'($urandom_range(1, 255)));
      end
    end
    push_byte(CH_NUL);
  endtask

  initial begin
    logic [LIMIT_W-1:0] lim;
    int unsigned        target;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Plus, escapes of both cases, broken escapes, a '%' that restarts an
    // escape, a high byte and an end inside an escape, all at the reset limit.
    push_text("a+%Fa%z%4x%%41%+");
    push_byte(8'hFF);
    push_text("%A");
    push_byte(CH_NUL);

    // Lowering the limit below the bytes already emitted drops the rest.
    push_text("xy");
    drain();
    write_limit(LIMIT_W'(1));
    push_byte("z");
    push_byte(CH_NUL);

    // A zero limit drops everything, the held escape bytes included.
    drain();
    write_limit('0);
    push_text("%4");
    push_byte(CH_NUL);

    drain();
    write_limit(LIMIT_W'(LIMIT_MAX));

    // Random phases, each at a limit of its own; the last runs without idling.
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        lim = ($urandom_range(0, 3) == 0) ? LIMIT_W'(LIMIT_MAX)
                                          : LIMIT_W'($urandom_range(1, 16));
        write_limit(lim);
      end
      if (p == PHASES - 1) calm = 1'b1;
      target = sent + RANDOM_ITEMS / PHASES;
      while (sent < target) begin
        send_random_string();
      end
    end

    push <= 1'b0;
    while (sb.pending() != 0) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.fails == 0) begin
      $display("tb_uri_percent_decoder_core OK");
    end else begin
      $display("tb_uri_percent_decoder_core NOT OK");
    end
    $finish;
  end

endmodule
